/* rtl/core/luma_histogram_stats_unit_macros.svh */
// Assertion macros shared by the histogram statistics unit.
`ifndef LUMA_HISTOGRAM_STATS_UNIT_MACROS_SVH
`define LUMA_HISTOGRAM_STATS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LHS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("histogram unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LHS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("histogram unit: next-cycle check failed");

`endif

/* rtl/core/lhs_pkg.sv */
`default_nettype none

package lhs_pkg;

   // Fixed field and storage widths.
   localparam int BINS    = 256;
   localparam int BIN_W   = 8;
   localparam int CNT_W   = 25;
   localparam int CFG_W   = 12;
   localparam int FRAC_W  = 17;
   localparam int SUM_W   = 33;
   localparam int WSUM_W  = 41;
   localparam int GOAL_W  = 42;
   localparam int DVD_W   = 49;
   localparam int RSP_W   = 64;
   localparam int IDX_W   = 3;
   localparam int SHIFT_W = 16;

   localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
   localparam logic [BIN_W-1:0]  MEAN_MAX = 8'd255;
   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
   localparam logic [BIN_W-1:0]  TOP_BIN  = 8'd255;

   // Register indexes of the configuration port.
   localparam logic [IDX_W-1:0] REG_WINDOW_LEFT     = 3'd0;
   localparam logic [IDX_W-1:0] REG_WINDOW_RIGHT    = 3'd1;
   localparam logic [IDX_W-1:0] REG_WINDOW_TOP      = 3'd2;
   localparam logic [IDX_W-1:0] REG_WINDOW_BOTTOM   = 3'd3;
   localparam logic [IDX_W-1:0] REG_COLUMN_STEP     = 3'd4;
   localparam logic [IDX_W-1:0] REG_ROW_STEP        = 3'd5;
   localparam logic [IDX_W-1:0] REG_BRIGHT_FRACTION = 3'd6;

   typedef struct packed {
      logic [CFG_W-1:0]  window_left;
      logic [CFG_W-1:0]  window_right;
      logic [CFG_W-1:0]  window_top;
      logic [CFG_W-1:0]  window_bottom;
      logic [CFG_W-1:0]  column_step;
      logic [CFG_W-1:0]  row_step;
      logic [FRAC_W-1:0] bright_fraction;
   } lhs_cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_WALK_RD,
      ST_WALK_ACC,
      ST_MEAN_START,
      ST_DIV_MEAN,
      ST_DIV_FRAC,
      ST_EMIT
   } lhs_state_type;

   typedef struct packed {
      logic accept;
      logic walk_init;
      logic pix_write;
      logic walk_sel;
      logic walk_acc;
      logic swap;
      logic mean_start;
      logic mean_load;
      logic frac_start;
      logic emit;
   } lhs_cmd_type;

   typedef struct packed {
      logic hit;
      logic frame_end_in;
      logic frame_end_ff;
      logic walk_last;
      logic div_busy;
      logic out_free;
   } lhs_status_type;

endpackage

`default_nettype wire

/* rtl/core/lhs_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module lhs_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [lhs_pkg::DVD_W-1:0]  dividend,
   input  wire logic [lhs_pkg::CNT_W-1:0]  divisor,
   output logic                            busy,
   output logic [lhs_pkg::DVD_W-1:0]       quotient
);

   localparam int CNTR_W = $clog2(lhs_pkg::DVD_W + 1);

   logic [CNTR_W-1:0]            count_ff, count_in;
   logic [lhs_pkg::DVD_W-1:0]    quo_ff, quo_in;
   logic [lhs_pkg::CNT_W-1:0]    rem_ff, rem_in;
   logic [lhs_pkg::CNT_W:0]      trial;
   logic [lhs_pkg::CNT_W:0]      diff;
   logic                         take;

   // One trial subtraction per cycle.
   always_comb begin
      trial    = {rem_ff, quo_ff[lhs_pkg::DVD_W-1]};
      diff     = trial - {1'b0, divisor};
      take     = (trial >= {1'b0, divisor});
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (start) begin
         count_in = CNTR_W'(lhs_pkg::DVD_W);
         quo_in   = dividend;
         rem_in   = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         quo_in   = {quo_ff[lhs_pkg::DVD_W-2:0], take};
         rem_in   = take ? diff[lhs_pkg::CNT_W-1:0] : trial[lhs_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = (count_ff != '0);
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* rtl/core/lhs_ctrl.sv */
`default_nettype none

// Sequencer for pixel updates and the end-of-frame walk.
module lhs_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire lhs_pkg::lhs_status_type status,
   output lhs_pkg::lhs_cmd_type         cmd
);

   lhs_pkg::lhs_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lhs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lhs_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (status.hit) begin
                  state_in = lhs_pkg::ST_PIX_RD;
               end else if (status.frame_end_in) begin
                  state_in = lhs_pkg::ST_WALK_RD;
               end
            end
         end
         lhs_pkg::ST_PIX_RD: state_in = lhs_pkg::ST_PIX_WR;
         lhs_pkg::ST_PIX_WR: begin
            state_in = status.frame_end_ff ? lhs_pkg::ST_WALK_RD : lhs_pkg::ST_IDLE;
         end
         lhs_pkg::ST_WALK_RD: state_in = lhs_pkg::ST_WALK_ACC;
         lhs_pkg::ST_WALK_ACC: begin
            state_in = status.walk_last ? lhs_pkg::ST_MEAN_START : lhs_pkg::ST_WALK_RD;
         end
         lhs_pkg::ST_MEAN_START: state_in = lhs_pkg::ST_DIV_MEAN;
         lhs_pkg::ST_DIV_MEAN: begin
            if (!status.div_busy) begin
               state_in = lhs_pkg::ST_DIV_FRAC;
            end
         end
         lhs_pkg::ST_DIV_FRAC: begin
            if (!status.div_busy) begin
               state_in = lhs_pkg::ST_EMIT;
            end
         end
         lhs_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = lhs_pkg::ST_IDLE;
            end
         end
         default: state_in = lhs_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         lhs_pkg::ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.accept    = req_tvalid;
            cmd.walk_init = req_tvalid && status.frame_end_in;
         end
         lhs_pkg::ST_PIX_RD: begin
         end
         lhs_pkg::ST_PIX_WR: cmd.pix_write = 1'b1;
         lhs_pkg::ST_WALK_RD: cmd.walk_sel = 1'b1;
         lhs_pkg::ST_WALK_ACC: begin
            cmd.walk_sel = 1'b1;
            cmd.walk_acc = 1'b1;
            cmd.swap     = status.walk_last;
         end
         lhs_pkg::ST_MEAN_START: cmd.mean_start = 1'b1;
         lhs_pkg::ST_DIV_MEAN: begin
            cmd.mean_load  = !status.div_busy;
            cmd.frac_start = !status.div_busy;
         end
         lhs_pkg::ST_DIV_FRAC: begin
         end
         lhs_pkg::ST_EMIT: cmd.emit = status.out_free;
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/lhs_datapath.sv */
`default_nettype none

// Grid sampling, histogram banks, frame statistics and the result register.
module lhs_datapath #(
   parameter int MAX_DIM = 4096
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lhs_pkg::lhs_cfg_type       cfg,
   input  wire lhs_pkg::lhs_cmd_type       cmd,
   output lhs_pkg::lhs_status_type         status,
   input  wire logic [lhs_pkg::BIN_W-1:0]  luma,
   input  wire logic                       line_end,
   input  wire logic                       frame_end,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [lhs_pkg::RSP_W-1:0]       rsp_tdata
);

   localparam int POS_W = $clog2(MAX_DIM);
   localparam int CW    = (POS_W > lhs_pkg::CFG_W) ? POS_W : lhs_pkg::CFG_W;
   localparam logic [CW-1:0] LIM = CW'(MAX_DIM - 1);
   localparam int PAD_W = lhs_pkg::RSP_W - lhs_pkg::CNT_W - 2 * lhs_pkg::BIN_W
                          - lhs_pkg::FRAC_W;

   // Position state.
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [CW-1:0] ncol_ff, ncol_in, nrow_ff, nrow_in;
   logic [CW-1:0] left_x, right_x, top_x, bottom_x, cstep_x, rstep_x;
   logic [CW:0]   ncol_sum, nrow_sum, col_sum, row_sum;
   logic [CW-1:0] ncol_adv;
   logic          row_act, hit;

   // Histogram banks and their valid bits.
   logic [lhs_pkg::CNT_W-1:0] mem0 [lhs_pkg::BINS];
   logic [lhs_pkg::CNT_W-1:0] mem1 [lhs_pkg::BINS];
   logic [lhs_pkg::BINS-1:0]  val0_ff, val1_ff;
   logic [lhs_pkg::CNT_W-1:0] rd0_ff, rd1_ff;
   logic                      rv0_ff, rv1_ff;
   logic                      bank_ff;
   logic [lhs_pkg::BIN_W-1:0] raddr;
   logic [lhs_pkg::CNT_W-1:0] d0, d1, cur_data, ref_data, bin_inc, bin_min;

   // Pixel and walk registers.
   logic [lhs_pkg::BIN_W-1:0]  luma_ff;
   logic                       fe_ff;
   logic [lhs_pkg::CNT_W-1:0]  counted_ff, stat_n_ff;
   logic [lhs_pkg::BIN_W-1:0]  idx_ff;
   logic [lhs_pkg::SUM_W-1:0]  run_ff, sim_ff;
   logic [lhs_pkg::WSUM_W-1:0] wsum_ff;
   logic [lhs_pkg::GOAL_W-1:0] goal_ff;
   logic [lhs_pkg::BIN_W-1:0]  thr_ff, mean_ff;
   logic                       found_ff;
   logic [lhs_pkg::SUM_W-1:0]  prod;
   logic [lhs_pkg::DVD_W-1:0]  run_shift, div_dividend, quotient;
   logic                       div_busy;
   logic [lhs_pkg::FRAC_W-1:0] frac_res;
   logic                       rsp_valid_ff;
   logic [lhs_pkg::RSP_W-1:0]  rsp_data_ff;

   // Sampling decision and the next positions.
   always_comb begin
      left_x   = CW'(cfg.window_left);
      right_x  = CW'(cfg.window_right);
      top_x    = CW'(cfg.window_top);
      bottom_x = CW'(cfg.window_bottom);
      cstep_x  = CW'(cfg.column_step);
      rstep_x  = CW'(cfg.row_step);
      row_act  = (row_ff == nrow_ff) && (row_ff >= top_x) && (row_ff < bottom_x)
                 && (row_ff < LIM);
      hit      = row_act && (col_ff == ncol_ff) && (col_ff >= left_x)
                 && (col_ff < right_x) && (col_ff < LIM);
      ncol_sum = {1'b0, ncol_ff} + {1'b0, cstep_x};
      nrow_sum = {1'b0, nrow_ff} + {1'b0, rstep_x};
      col_sum  = {1'b0, col_ff} + (CW+1)'(1);
      row_sum  = {1'b0, row_ff} + (CW+1)'(1);
      ncol_adv = ncol_ff;
      if (hit) begin
         ncol_adv = (ncol_sum > {1'b0, LIM}) ? LIM : ncol_sum[CW-1:0];
      end
      col_in  = col_ff;
      row_in  = row_ff;
      ncol_in = ncol_ff;
      nrow_in = nrow_ff;
      if (cmd.accept) begin
         if (line_end || frame_end) begin
            if (row_act) begin
               nrow_in = (nrow_sum > {1'b0, LIM}) ? LIM : nrow_sum[CW-1:0];
            end
            row_in  = (row_sum > {1'b0, LIM}) ? LIM : row_sum[CW-1:0];
            col_in  = '0;
            ncol_in = left_x;
         end else begin
            col_in  = (col_sum > {1'b0, LIM}) ? LIM : col_sum[CW-1:0];
            ncol_in = ncol_adv;
         end
         if (frame_end) begin
            row_in  = '0;
            nrow_in = top_x;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         ncol_ff <= '0;
         nrow_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         ncol_ff <= ncol_in;
         nrow_ff <= nrow_in;
      end
   end

   // Bank reads, registered; an entry without its valid bit reads as zero.
   assign raddr = cmd.walk_sel ? idx_ff : luma_ff;

   always_ff @(posedge clock) begin
      rd0_ff <= mem0[raddr];
      rd1_ff <= mem1[raddr];
      if (cmd.pix_write && !bank_ff) begin
         mem0[luma_ff] <= bin_inc;
      end
      if (cmd.pix_write && bank_ff) begin
         mem1[luma_ff] <= bin_inc;
      end
   end

   always_ff @(posedge clock) begin
      rv0_ff <= val0_ff[raddr];
      rv1_ff <= val1_ff[raddr];
   end

   always_comb begin
      d0       = rv0_ff ? rd0_ff : '0;
      d1       = rv1_ff ? rd1_ff : '0;
      cur_data = bank_ff ? d1 : d0;
      ref_data = bank_ff ? d0 : d1;
      bin_inc  = (cur_data == lhs_pkg::CNT_MAX) ? cur_data : cur_data + 1'b1;
      bin_min  = (cur_data < ref_data) ? cur_data : ref_data;
   end

   // Valid bits and bank swap: the old reference bank becomes the empty current one.
   always_ff @(posedge clock) begin
      if (reset) begin
         val0_ff <= '0;
         val1_ff <= '0;
         bank_ff <= 1'b0;
      end else begin
         if (cmd.pix_write && !bank_ff) begin
            val0_ff[luma_ff] <= 1'b1;
         end
         if (cmd.pix_write && bank_ff) begin
            val1_ff[luma_ff] <= 1'b1;
         end
         if (cmd.swap) begin
            bank_ff <= !bank_ff;
            if (bank_ff) begin
               val0_ff <= '0;
            end else begin
               val1_ff <= '0;
            end
         end
      end
   end

   // Pixel capture and the frame's sample count.
   always_ff @(posedge clock) begin
      if (reset) begin
         counted_ff <= '0;
         fe_ff      <= 1'b0;
      end else begin
         if (cmd.accept) begin
            fe_ff <= frame_end;
         end
         if (cmd.pix_write && counted_ff != lhs_pkg::CNT_MAX) begin
            counted_ff <= counted_ff + 1'b1;
         end
         if (cmd.swap) begin
            counted_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         luma_ff <= luma;
      end
      if (cmd.swap) begin
         stat_n_ff <= counted_ff;
      end
      goal_ff <= cfg.bright_fraction * counted_ff;
   end

   // Walk from the top bin down: weighted sum, overlap and threshold search.
   always_comb begin
      prod      = cur_data * idx_ff;
      run_shift = {run_ff, {lhs_pkg::SHIFT_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         idx_ff   <= lhs_pkg::TOP_BIN;
         run_ff   <= '0;
         sim_ff   <= '0;
         wsum_ff  <= '0;
         thr_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.walk_acc) begin
         if (!found_ff && idx_ff != '0 && run_shift > lhs_pkg::DVD_W'(goal_ff)) begin
            thr_ff   <= idx_ff;
            found_ff <= 1'b1;
         end
         run_ff  <= run_ff + lhs_pkg::SUM_W'(cur_data);
         sim_ff  <= sim_ff + lhs_pkg::SUM_W'(bin_min);
         wsum_ff <= wsum_ff + lhs_pkg::WSUM_W'(prod);
         if (idx_ff != '0) begin
            idx_ff <= idx_ff - 1'b1;
         end
      end
   end

   // Shared divider: first the mean, then the overlap fraction.
   assign div_dividend = cmd.mean_start ? lhs_pkg::DVD_W'(wsum_ff)
                                        : {sim_ff, {lhs_pkg::SHIFT_W{1'b0}}};

   lhs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.mean_start || cmd.frac_start),
      .dividend (div_dividend),
      .divisor  (stat_n_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.mean_load) begin
         if (stat_n_ff == '0) begin
            mean_ff <= '0;
         end else if (quotient > lhs_pkg::DVD_W'(lhs_pkg::MEAN_MAX)) begin
            mean_ff <= lhs_pkg::MEAN_MAX;
         end else begin
            mean_ff <= quotient[lhs_pkg::BIN_W-1:0];
         end
      end
   end

   always_comb begin
      if (stat_n_ff == '0) begin
         frac_res = '0;
      end else if (quotient > lhs_pkg::DVD_W'(lhs_pkg::FRAC_ONE)) begin
         frac_res = lhs_pkg::FRAC_ONE;
      end else begin
         frac_res = quotient[lhs_pkg::FRAC_W-1:0];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, frac_res, thr_ff, mean_ff, stat_n_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      status.hit          = hit;
      status.frame_end_in = frame_end;
      status.frame_end_ff = fe_ff;
      status.walk_last    = (idx_ff == '0);
      status.div_busy     = div_busy;
      status.out_free     = !rsp_valid_ff || rsp_tready;
   end

endmodule

`default_nettype wire

/* rtl/core/luma_histogram_stats_unit.sv */
// Channel | Dir | Payload
// req     | in  | tdata[7:0] luma, tuser line_end, tlast frame_end
// rsp     | out | tdata: count[24:0], mean[32:25], threshold[40:33], similarity[57:41]
// csr     | in  | wen, index[2:0], wdata[16:0]
//
// A pixel outside the sampling grid is taken in ST_IDLE alone; a sampled pixel then
// passes ST_PIX_RD and ST_PIX_WR for the read-modify-write of its bin, as bank reads
// are registered. A frame-end pixel then walks the 256 bins, reading and accumulating
// each, and makes two 49-step passes of the shared divider.
// Reset is synchronous; histogram banks are cleared through per-entry valid bits.
// A result waits in the output register while the next frame's pixels are taken.
`default_nettype none

`include "luma_histogram_stats_unit_macros.svh"

module luma_histogram_stats_unit #(
   parameter int MAX_DIM = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // luma
   input  wire logic        req_tuser,   // line_end
   input  wire logic        req_tlast,   // frame_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // sample_count, mean, threshold, similarity
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_index,
   input  wire logic [16:0] csr_wdata
);

   lhs_pkg::lhs_cfg_type    cfg_ff, cfg_in;
   lhs_pkg::lhs_cmd_type    cmd;
   lhs_pkg::lhs_status_type status;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            lhs_pkg::REG_WINDOW_LEFT:     cfg_in.window_left   = csr_wdata[11:0];
            lhs_pkg::REG_WINDOW_RIGHT:    cfg_in.window_right  = csr_wdata[11:0];
            lhs_pkg::REG_WINDOW_TOP:      cfg_in.window_top    = csr_wdata[11:0];
            lhs_pkg::REG_WINDOW_BOTTOM:   cfg_in.window_bottom = csr_wdata[11:0];
            lhs_pkg::REG_COLUMN_STEP:     cfg_in.column_step   = csr_wdata[11:0];
            lhs_pkg::REG_ROW_STEP:        cfg_in.row_step      = csr_wdata[11:0];
            lhs_pkg::REG_BRIGHT_FRACTION: cfg_in.bright_fraction = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_left     <= 12'd0;
         cfg_ff.window_right    <= 12'd4095;
         cfg_ff.window_top      <= 12'd0;
         cfg_ff.window_bottom   <= 12'd4095;
         cfg_ff.column_step     <= 12'd1;
         cfg_ff.row_step        <= 12'd1;
         cfg_ff.bright_fraction <= 17'd32768;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lhs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lhs_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .status     (status),
      .luma       (req_tdata),
      .line_end   (req_tuser),
      .frame_end  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A frame-end item always starts the walk, so no item is taken next cycle.
   `LHS_ASSERT_NEXT(a_frame_end_stalls, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)
   // A result is loaded only into a free output register.
   `LHS_ASSERT_SAME(a_emit_free, clock, reset, cmd.emit, !rsp_tvalid || rsp_tready)
   // The bank swap never coincides with a bin update.
   `LHS_ASSERT_SAME(a_swap_no_write, clock, reset, cmd.swap, !cmd.pix_write && !req_tready)

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

// Checks one frame summary at a time against the predicted values.
class frame_stats_board;
   logic [63:0] pending[$];
   int mismatches;
   int unexpected;

   function new();
      mismatches = 0;
      unexpected = 0;
   endfunction

   // Note the packed summary that a frame-end item will produce.
   function void note_frame(logic [63:0] packed_stats);
      pending.push_back(packed_stats);
   endfunction

   // Compare one output item with the oldest waiting summary, field by field.
   function void check_summary(logic [63:0] got);
      logic [63:0] want;
      if (pending.size() == 0) begin
         unexpected++;
         if (mismatches + unexpected <= 10)
            $display("unexpected summary item %h", got);
         return;
      end
      want = pending.pop_front();
      if (got[24:0] !== want[24:0] || got[32:25] !== want[32:25] ||
          got[40:33] !== want[40:33] || got[57:41] !== want[57:41]) begin
         mismatches++;
         if (mismatches + unexpected <= 10)
            $display("summary mismatch: count %0d/%0d mean %0d/%0d thr %0d/%0d sim %0d/%0d",
                     want[24:0], got[24:0], want[32:25], got[32:25],
                     want[40:33], got[40:33], want[57:41], got[57:41]);
      end
   endfunction
endclass

module tb_top;
   localparam int LIM = 4095;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;   // luma
   logic req_tuser = 1'b0;       // line_end
   logic req_tlast = 1'b0;       // frame_end
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;       // count, mean, threshold, similarity
   logic csr_wen = 1'b0;
   logic [2:0] csr_index = '0;
   logic [16:0] csr_wdata = '0;

   luma_histogram_stats_unit dut (.*);

   always #1 clock = ~clock;

   frame_stats_board board = new();

   // Predictor state.
   logic [11:0] win_l, win_r, win_t, win_b, col_step, rw_step;
   logic [16:0] bright_frac;
   logic [24:0] cur_bins[256];
   logic [24:0] ref_bins[256];
   logic [24:0] n_counted;
   int unsigned col_pos, row_pos, next_col, next_row;

   bit quiet_phase = 0;
   bit hold_long = 0;
   int frames_seen = 0;

   function automatic int unsigned sat(int unsigned a, int unsigned b, int unsigned lim);
      return (a + b > lim) ? lim : a + b;
   endfunction

   function automatic void predict_reset();
      win_l = 0; win_r = 4095; win_t = 0; win_b = 4095;
      col_step = 1; rw_step = 1; bright_frac = 17'd32768;
      foreach (cur_bins[i]) begin
         cur_bins[i] = '0;
         ref_bins[i] = '0;
      end
      n_counted = '0;
      col_pos = 0; row_pos = 0; next_col = 0; next_row = 0;
   endfunction

   // Advance the predicted histogram state by one pixel.
   function automatic void predict_pixel(logic [7:0] luma, logic le, logic fe);
      bit on_row;
      longint unsigned n, wsum, run, sim, goal, mean, thr, frac;
      bit found;
      on_row = row_pos == next_row && row_pos >= win_t && row_pos < win_b && row_pos < LIM;
      if (on_row && col_pos == next_col && col_pos >= win_l && col_pos < win_r &&
          col_pos < LIM) begin
         cur_bins[luma] = sat(cur_bins[luma], 1, 25'h1FFFFFF);
         n_counted = sat(n_counted, 1, 25'h1FFFFFF);
         next_col = sat(next_col, col_step, LIM);
      end
      if (le || fe) begin
         if (on_row) next_row = sat(next_row, rw_step, LIM);
         row_pos = sat(row_pos, 1, LIM);
         col_pos = 0;
         next_col = win_l;
      end else begin
         col_pos = sat(col_pos, 1, LIM);
      end
      if (!fe) return;
      n = n_counted; wsum = 0; run = 0; sim = 0; mean = 0; thr = 0; frac = 0;
      goal = longint'(bright_frac) * n;
      found = 0;
      for (int i = 0; i < 256; i++) begin
         wsum += longint'(cur_bins[i]) * i;
         sim += (cur_bins[i] < ref_bins[i]) ? cur_bins[i] : ref_bins[i];
      end
      for (int i = 255; i != 0; i--) begin
         if (!found && (run << 16) > goal) begin
            thr = i;
            found = 1;
         end
         run += cur_bins[i];
      end
      if (n != 0) begin
         mean = wsum / n;
         if (mean > 255) mean = 255;
         frac = (sim << 16) / n;
         if (frac > 65536) frac = 65536;
      end
      board.note_frame({6'd0, frac[16:0], thr[7:0], mean[7:0], n[24:0]});
      foreach (cur_bins[i]) begin
         ref_bins[i] = cur_bins[i];
         cur_bins[i] = '0;
      end
      n_counted = '0;
      row_pos = 0;
      next_row = win_t;
   endfunction

   // Register write, only while the block is idle.
   task automatic write_reg(logic [2:0] idx, logic [16:0] val);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (idx)
         lhs_pkg::REG_WINDOW_LEFT:     win_l = val[11:0];
         lhs_pkg::REG_WINDOW_RIGHT:    win_r = val[11:0];
         lhs_pkg::REG_WINDOW_TOP:      win_t = val[11:0];
         lhs_pkg::REG_WINDOW_BOTTOM:   win_b = val[11:0];
         lhs_pkg::REG_COLUMN_STEP:     col_step = val[11:0];
         lhs_pkg::REG_ROW_STEP:        rw_step = val[11:0];
         lhs_pkg::REG_BRIGHT_FRACTION: bright_frac = val;
         default: ;
      endcase
   endtask

   task automatic set_window(int l, int r, int t, int b, int cs, int rs, int bf);
      write_reg(lhs_pkg::REG_WINDOW_LEFT, 17'(l));
      write_reg(lhs_pkg::REG_WINDOW_RIGHT, 17'(r));
      write_reg(lhs_pkg::REG_WINDOW_TOP, 17'(t));
      write_reg(lhs_pkg::REG_WINDOW_BOTTOM, 17'(b));
      write_reg(lhs_pkg::REG_COLUMN_STEP, 17'(cs));
      write_reg(lhs_pkg::REG_ROW_STEP, 17'(rs));
      write_reg(lhs_pkg::REG_BRIGHT_FRACTION, 17'(bf));
   endtask

   // Offer one pixel item and wait until it is accepted. The offer stays up
   // into the next item or an idle gap; drain takes it down.
   task automatic send_pixel(logic [7:0] luma, logic le, logic fe);
      int gap;
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= luma;
      req_tuser <= le;
      req_tlast <= fe;
      do @(posedge clock); while (!req_tready);
      predict_pixel(luma, le, fe);
      @(negedge clock);
   endtask

   // A frame of w x h pixels; lumas cluster near a random center now and then.
   task automatic send_frame(int w, int h, bit drop_frame_end);
      int base;
      logic [7:0] px;
      base = $urandom_range(0, 255);
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++) begin
            px = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 255)) :
                 8'(base + $urandom_range(0, 15));
            send_pixel(px, x == w - 1, !drop_frame_end && x == w - 1 && y == h - 1);
         end
   endtask

   // Take the offer down, then wait until every predicted summary has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (800) @(negedge clock);
   endtask

   // Receiver: random stalls, one long hold-off, none in the quiet phase.
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (hold_long) begin
            rsp_tready <= 1'b0;
            repeat (4000) @(negedge clock);
            hold_long = 0;
         end
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_summary(rsp_tdata);
         frames_seen++;
      end

   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int items;
      predict_reset();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset settings, empty window, extreme lumas, full fraction.
      send_pixel(8'd0, 1'b0, 1'b0);
      send_pixel(8'd255, 1'b1, 1'b0);
      send_pixel(8'd128, 1'b0, 1'b0);
      send_pixel(8'd255, 1'b1, 1'b1);
      send_pixel(8'd7, 1'b1, 1'b1);
      drain();
      set_window(4095, 4095, 4095, 4095, 4095, 4095, 17'h1FFFF);
      send_frame(3, 2, 0);
      drain();
      set_window(1, 3, 0, 2, 0, 0, 0);
      send_frame(4, 3, 0);
      send_frame(4, 3, 0);
      drain();
      set_window(0, 8, 0, 8, 1, 1, 65536);
      send_frame(4, 3, 0);
      drain();

      // Long hold-off so the output register fills and the input stalls.
      hold_long = 1;
      send_frame(2, 2, 0);
      send_frame(3, 2, 0);
      send_frame(2, 3, 0);
      drain();

      // Random frames with random windows and mostly small sizes.
      items = 0;
      while (items < 1800) begin
         int w, h;
         if ($urandom_range(0, 3) == 0) begin
            drain();
            set_window($urandom_range(0, 4), $urandom_range(0, 12), $urandom_range(0, 4),
                       $urandom_range(0, 12), $urandom_range(0, 3), $urandom_range(0, 3),
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 17'h1FFFF)
                                                 : $urandom_range(0, 65536));
         end
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 6);
         if (items > 1500) quiet_phase = 1;
         send_frame(w, h, $urandom_range(0, 15) == 0);
         items += w * h;
         if ($urandom_range(0, 2) == 0) drain();
      end
      send_pixel(8'd1, 1'b1, 1'b1);
      drain();

      if (board.mismatches == 0 && board.unexpected == 0 && board.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
